// ----- rtl/cuid_pkg.sv -----
package cuid_pkg;

   localparam int UID_W = 64;
   localparam int POS_W = 3;

   localparam logic [POS_W-1:0] POS_SAT = POS_W'(5);

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [UID_W-1:0] UID_NONE = '1;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [UID_W-1:0] value;
   } scan_result_type;

endpackage

// ----- rtl/cuid_scan.sv -----
module cuid_scan import cuid_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      ch,
   input  logic            last,
   output scan_result_type result
);

   logic             comment_ff, comment_in;
   logic             capture_ff, capture_in;
   logic             skip_ff, skip_in;
   logic             answered_ff, answered_in;
   logic [7:0]       recent_ff [3];
   logic [7:0]       recent_in [3];
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [UID_W-1:0] acc_ff, acc_in;

   logic swallow, digit_ok, matched, hit;

   always_comb begin
      swallow  = skip_ff && (ch == CHAR_SPACE);
      digit_ok = capture_ff && (ch inside {[CHAR_ZERO:CHAR_NINE]});
      matched  = (ch == CHAR_COLON) && comment_ff && (pos_ff >= POS_SAT) &&
                 (recent_ff[0] == CHAR_D) && (recent_ff[1] == CHAR_I) &&
                 (recent_ff[2] == CHAR_U);
      hit      = !answered_ff && !swallow && capture_ff && !digit_ok && !matched;

      result.valid = !answered_ff && (hit || last);
      result.found = hit;
      result.value = hit ? acc_ff : UID_NONE;
   end

   always_comb begin
      comment_in   = comment_ff;
      capture_in   = capture_ff;
      skip_in      = skip_ff;
      answered_in  = answered_ff;
      recent_in[0] = recent_ff[0];
      recent_in[1] = recent_ff[1];
      recent_in[2] = recent_ff[2];
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      if (last) begin
         comment_in   = 1'b0;
         capture_in   = 1'b0;
         skip_in      = 1'b0;
         answered_in  = 1'b0;
         recent_in[0] = '0;
         recent_in[1] = '0;
         recent_in[2] = '0;
         pos_in       = '0;
         acc_in       = '0;
      end else if (!answered_ff) begin
         skip_in = matched;
         if (!swallow) begin
            if (ch == CHAR_STAR && pos_ff != '0 && recent_ff[0] == CHAR_SLASH) begin
               comment_in = 1'b1;
            end
            if (ch == CHAR_SLASH && comment_ff && pos_ff != '0 &&
                recent_ff[0] == CHAR_STAR) begin
               comment_in = 1'b0;
            end
            if (matched) begin
               capture_in = 1'b1;
            end
            if (digit_ok) begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + UID_W'(ch - CHAR_ZERO);
            end
         end
         recent_in[0] = ch;
         recent_in[1] = recent_ff[0];
         recent_in[2] = recent_ff[1];
         if (pos_ff < POS_SAT) begin
            pos_in = pos_ff + POS_W'(1);
         end
         answered_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff   <= 1'b0;
         capture_ff   <= 1'b0;
         skip_ff      <= 1'b0;
         answered_ff  <= 1'b0;
         recent_ff[0] <= '0;
         recent_ff[1] <= '0;
         recent_ff[2] <= '0;
         pos_ff       <= '0;
         acc_ff       <= '0;
      end else if (accept) begin
         comment_ff   <= comment_in;
         capture_ff   <= capture_in;
         skip_ff      <= skip_in;
         answered_ff  <= answered_in;
         recent_ff[0] <= recent_in[0];
         recent_ff[1] <= recent_in[1];
         recent_ff[2] <= recent_in[2];
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
      end
   end

`ifndef SYNTHESIS
   a_skip_needs_capture: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> capture_ff)
      else $error("space swallow armed without capture");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_SAT)
      else $error("position count past saturation");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (!capture_ff && !answered_ff && acc_ff == '0))
      else $error("state not cleared after last byte");
`endif

endmodule

// ----- rtl/comment_uid_extractor_core.sv -----
// Result: rsp_* is registered and carries a result in the cycle after the byte that causes it is transferred.
// Throughput: one byte per cycle while req_stall is low; the per-byte state update is combinational.
// Back pressure: req_stall follows rsp_stall only while a result waits in the output register.
// Reset: synchronous, active high; clears scan state and drops rsp_valid.
module comment_uid_extractor_core import cuid_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_ch,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [UID_W-1:0] rsp_uid_value,
   output logic             rsp_found
);

   scan_result_type  scan_res;
   logic             req_accept;
   logic             valid_ff, valid_in;
   logic             found_ff;
   logic [UID_W-1:0] value_ff;

   assign req_stall  = valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   cuid_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .ch     (req_ch),
      .last   (req_last),
      .result (scan_res)
   );

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (req_accept && scan_res.valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && scan_res.valid) begin
         found_ff <= scan_res.found;
         value_ff <= scan_res.value;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_uid_value = value_ff;

`ifndef SYNTHESIS
   a_none_is_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_uid_value == UID_NONE))
      else $error("end without uid must carry all ones");

   a_result_registered: assert property (@(posedge clock) disable iff (reset)
      (req_accept && scan_res.valid) |=> rsp_valid)
      else $error("no result after a result-producing byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !req_accept)
      else $error("byte transferred while result held");
`endif

endmodule
